FILE: hdl/rc4_pkg.sv
// shared constants and types of the rc4 engine
package rc4_pkg;

    localparam int BYTE_W      = 8;
    localparam int S_DEPTH     = 256;
    localparam int KEY_MAX_DEF = 256;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_RS,
        ST_K_RJ,
        ST_K_WJ,
        ST_K_WN,
        ST_D_RJ,
        ST_D_WI,
        ST_D_WJ,
        ST_D_KS,
        ST_FIN
    } state_t;

endpackage

FILE: hdl/rc4_in_if.sv
// request channel of the rc4 engine: key and data bytes
interface rc4_in_if;

    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output op, output value, output last, input ready);
    modport sink (input valid, input op, input value, input last, output ready);

endinterface

FILE: hdl/rc4_out_if.sv
// result channel of the rc4 engine: processed data bytes
interface rc4_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    logic       no_key;

    modport source (output valid, output out_byte, output last_out, output no_key, input ready);
    modport sink (input valid, input out_byte, input last_out, input no_key, output ready);

endinterface

FILE: hdl/rc4_stream_cipher.sv
// rc4 engine: key store, key schedule and keystream generator on one permutation memory
//
// A key byte is taken while idle and kept in the key store while it has room. The key
// byte marked last starts the key schedule, during which no request is taken: the
// permutation memory is filled with the identity, then the schedule runs in 256 steps,
// each through ST_K_RS, ST_K_RJ, ST_K_WJ and ST_K_WN. A data byte passes ST_D_RJ,
// ST_D_WI, ST_D_WJ and ST_D_KS, a sequence set by the single read and single write port
// of the permutation memory (read S[i], read S[j], two swap writes, keystream read), into
// the result register, waiting in ST_FIN while that register is full; a data byte before
// any completed key goes via ST_FIN into it, unchanged and with no_key set. The result
// register frees the request side: the next request is taken while a result still waits.
module rc4_stream_cipher #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rc4_in_if.sink     req,
    rc4_out_if.source  res
);
    import rc4_pkg::*;

    localparam int CNT_W  = $clog2(KEY_MAX + 1);
    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // permutation memory and key store
    logic [BYTE_W-1:0] s_mem [S_DEPTH];
    logic [BYTE_W-1:0] key_mem [KEY_MAX];

    logic              s_we;
    logic [7:0]        s_waddr;
    logic [7:0]        s_wdata;
    logic [7:0]        s_raddr;
    logic [7:0]        s_rdata;

    logic              key_we;
    logic [KIDX_W-1:0] key_waddr;
    logic [KIDX_W-1:0] key_raddr;
    logic [7:0]        key_rdata;

    // control state
    state_t            state_reg, state_next;
    logic [7:0]        n_reg, n_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic [7:0]        jj_reg, jj_next;
    logic [7:0]        i_reg, i_next;
    logic [7:0]        j_reg, j_next;
    logic              keyed_reg, keyed_next;
    logic              res_valid_reg, res_valid_next;

    // payload
    logic [7:0]        sv_reg, sv_next;
    logic [7:0]        sj_reg, sj_next;
    logic              fwd_reg, fwd_next;
    logic [7:0]        value_reg, value_next;
    logic              last_reg, last_next;
    logic [7:0]        ks_reg, ks_next;
    logic              nokey_reg, nokey_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_last_reg, res_last_next;
    logic              res_nokey_reg, res_nokey_next;

    logic [CNT_W-1:0]  kidx_inc;
    logic [CNT_W-1:0]  count_inc;
    logic [7:0]        jj_sum;
    logic [7:0]        j_sum;
    logic [7:0]        t_addr;
    logic [7:0]        ks;
    logic              res_free;

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rdata <= s_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= req.value;
        end
        key_rdata <= key_mem[key_raddr];
    end

    assign kidx_inc  = CNT_W'(kidx_reg) + CNT_W'(1);
    assign count_inc = key_count_reg + CNT_W'(1);
    assign jj_sum    = jj_reg + key_rdata + s_rdata;
    assign j_sum     = j_reg + s_rdata;
    assign t_addr    = sv_reg + sj_reg;
    assign ks        = fwd_reg ? sv_reg : s_rdata;
    assign res_free  = !res_valid_reg || res.ready;

    assign res.valid    = res_valid_reg;
    assign res.out_byte = res_byte_reg;
    assign res.last_out = res_last_reg;
    assign res.no_key   = res_nokey_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        kidx_next      = kidx_reg;
        len_next       = len_reg;
        key_count_next = key_count_reg;
        jj_next        = jj_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        keyed_next     = keyed_reg;
        sv_next        = sv_reg;
        sj_next        = sj_reg;
        fwd_next       = fwd_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        ks_next        = ks_reg;
        nokey_next     = nokey_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_byte_next  = res_byte_reg;
        res_last_next  = res_last_reg;
        res_nokey_next = res_nokey_reg;

        s_we      = 1'b0;
        s_waddr   = n_reg;
        s_wdata   = n_reg;
        s_raddr   = n_reg;
        key_we    = 1'b0;
        key_waddr = key_count_reg[KIDX_W-1:0];
        key_raddr = kidx_reg;
        req.ready = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.op == OP_KEY)
                    begin
                        if (key_count_reg < CNT_W'(KEY_MAX))
                        begin
                            key_we         = 1'b1;
                            key_count_next = count_inc;
                        end
                        if (req.last)
                        begin
                            // saturated count stays at the key length
                            len_next       = (key_count_reg < CNT_W'(KEY_MAX)) ?
                                             count_inc : key_count_reg;
                            key_count_next = '0;
                            n_next         = '0;
                            state_next     = ST_FILL;
                        end
                    end
                    else
                    begin
                        value_next = req.value;
                        last_next  = req.last;
                        if (!keyed_reg)
                        begin
                            ks_next    = '0;
                            nokey_next = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            i_next     = i_reg + 8'd1;
                            s_raddr    = i_reg + 8'd1;
                            state_next = ST_D_RJ;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                s_we   = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hff)
                begin
                    kidx_next  = '0;
                    jj_next    = '0;
                    state_next = ST_K_RS;
                end
            end
            ST_K_RS:
            begin
                state_next = ST_K_RJ;
            end
            ST_K_RJ:
            begin
                jj_next    = jj_sum;
                sv_next    = s_rdata;
                s_raddr    = jj_sum;
                state_next = ST_K_WJ;
            end
            ST_K_WJ:
            begin
                s_we       = 1'b1;
                s_wdata    = s_rdata;
                state_next = ST_K_WN;
            end
            ST_K_WN:
            begin
                s_we      = 1'b1;
                s_waddr   = jj_reg;
                s_wdata   = sv_reg;
                n_next    = n_reg + 8'd1;
                kidx_next = (kidx_inc == len_reg) ? '0 : kidx_inc[KIDX_W-1:0];
                if (n_reg == 8'hff)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K_RS;
                end
            end
            ST_D_RJ:
            begin
                sv_next    = s_rdata;
                j_next     = j_sum;
                s_raddr    = j_sum;
                state_next = ST_D_WI;
            end
            ST_D_WI:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg;
                s_wdata    = s_rdata;
                sj_next    = s_rdata;
                state_next = ST_D_WJ;
            end
            ST_D_WJ:
            begin
                s_we       = 1'b1;
                s_waddr    = j_reg;
                s_wdata    = sv_reg;
                s_raddr    = t_addr;
                // keystream read hits the entry written this cycle
                fwd_next   = (t_addr == j_reg);
                state_next = ST_D_KS;
            end
            ST_D_KS:
            begin
                ks_next    = ks;
                nokey_next = 1'b0;
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_byte_next  = value_reg ^ ks;
                    res_last_next  = last_reg;
                    res_nokey_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_byte_next  = value_reg ^ ks_reg;
                    res_last_next  = last_reg;
                    res_nokey_next = nokey_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            kidx_reg      <= '0;
            len_reg       <= '0;
            key_count_reg <= '0;
            jj_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            kidx_reg      <= kidx_next;
            len_reg       <= len_next;
            key_count_reg <= key_count_next;
            jj_reg        <= jj_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sv_reg        <= sv_next;
        sj_reg        <= sj_next;
        fwd_reg       <= fwd_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
        ks_reg        <= ks_next;
        nokey_reg     <= nokey_next;
        res_byte_reg  <= res_byte_next;
        res_last_reg  <= res_last_next;
        res_nokey_reg <= res_nokey_next;
    end

endmodule

FILE: hdl/rc4_checker.sv
// port-level checks of the rc4 engine, bound to the top level
module rc4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_op,
    input logic       req_last,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte,
    input logic       res_last_out,
    input logic       res_no_key
);
    import rc4_pkg::*;

    // a stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_byte) &&
            $stable(res_last_out) && $stable(res_no_key))
        else $error("result changed while stalled");

    // a data request keeps the engine busy in the next cycle
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == OP_DATA |=> !req_ready)
        else $error("request taken right after a data request");

    // a key byte that is not last leaves the engine ready to take another request
    a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == OP_KEY && !req_last |=> req_ready)
        else $error("engine busy after a plain key byte");

    // the last key byte starts the schedule
    a_sched_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == OP_KEY && req_last |=> ##1 !req_ready)
        else $error("request taken during the key schedule");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_op       (req.op),
    .req_last     (req.last),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_out_byte (res.out_byte),
    .res_last_out (res.last_out),
    .res_no_key   (res.no_key)
);
